### rtl/assert_macros.svh
// Assertion macros for the RTL files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, held off during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dvf_pkg.sv
// Package for the dual volume fade ramp: constants, widths, state and opcode types.
// No dependencies.
`timescale 1ns / 1ps

package dvf_pkg;

  localparam int TICK_RATE_HZ     = 120;
  localparam int MASTER_RESET_VOL = 16383;
  localparam int CD_RESET_VOL     = 16383;

  localparam int MS_W     = 16;
  localparam int VOL_W    = 15;
  localparam int FIX_W    = 32;
  localparam int FRAC_W   = 16;
  localparam int MS_PER_S = 1000;

  // longest fade in ticks, and the widths that follow from it
  localparam int MAX_TICKS = ((2 ** MS_W - 1) * TICK_RATE_HZ) / MS_PER_S + 1;
  localparam int TICKS_W   = $clog2(MAX_TICKS + 1);
  localparam int MS_DIV_W  = $clog2(MS_PER_S + 1);
  localparam int DEN_W     = (TICKS_W > MS_DIV_W) ? TICKS_W : MS_DIV_W;

  // ms * rate / 1000 as a reciprocal multiply, exact over the whole ms range
  localparam int     MS_RATE_W = $clog2((2 ** MS_W - 1) * TICK_RATE_HZ + 1);
  localparam int     RECIP_SH  = MS_RATE_W + $clog2(MS_PER_S);
  localparam longint RECIP_M   = ((longint'(1) << RECIP_SH) + MS_PER_S - 1) / MS_PER_S;
  localparam int     RECIP_W   = $clog2(RECIP_M + 1);
  localparam int     PROD_W    = MS_RATE_W + RECIP_W;

  localparam int DIV_STEPS = FIX_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_TICK,
    S_DIV_MS,
    S_DIFF,
    S_ABS,
    S_DIV_STEP,
    S_NEG,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SET   = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

endpackage

### rtl/dual_volume_fade_ramp.sv
// Dual linear volume fader (cd audio and master), 16.16 fixed point levels.
// Depends on dvf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  in_     | input     | in_tvalid / in_tready  | tdata: volume, fade_ms; tuser: opcode, channel
//  out_    | output    | out_tvalid / out_tready| tdata: levels, fading and push flags
//  cfg_    | input     | cfg_valid / cfg_ready  | cfg_data: timer_active
//
//  Per request: set volume and stop finish straight from the execute state, tick
//  updates each fader in turn, start fade uses a reciprocal multiply to turn ms into
//  ticks, then one 32-step pass of the shared restoring divider takes the level
//  difference by ticks; start fade with the timer off finishes straight away.
//  Adds, the difference and the sign fixes share one 32-bit adder under the sequencer.
//  Reset (rst_n low, synchronous) loads both levels with their reset volumes,
//  clears ticks, targets and steps, and sets timer_active.
//  in_tready is high only while the sequencer is idle. A finished result waits in
//  the output register; a new request can be taken meanwhile and stalls at its
//  end until the previous result has gone out.

module dual_volume_fade_ramp
  import dvf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [14:0] volume, [30:15] fade_ms, [31] zero
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // [1:0] opcode, [2] channel

  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [14:0] cd_level, [29:15] master_level,
                                             // [30] cd_fading, [31] master_fading,
                                             // [32] cd_push, [33] master_push, [39:34] zero

  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_data    // timer_active
);

  localparam int OUT_PAD_W = OUT_TDATA_W - 2 * VOL_W - 4;

  state_t state_r, state_nxt;

  // fader state, index 0 cd audio, 1 master
  logic [FIX_W-1:0]   level_r  [2], level_nxt  [2];
  logic [FIX_W-1:0]   target_r [2], target_nxt [2];
  logic [FIX_W-1:0]   step_r   [2], step_nxt   [2];
  logic [TICKS_W-1:0] ticks_r  [2], ticks_nxt  [2];

  logic timer_active_r, timer_active_nxt;

  // latched request
  op_t              op_r,  op_nxt;
  logic             ch_r,  ch_nxt;
  logic [VOL_W-1:0] vol_r, vol_nxt;
  logic [MS_W-1:0]  ms_r,  ms_nxt;

  // sequencer and divider registers
  logic             idx_r, idx_nxt;
  logic [1:0]       push_r, push_nxt;
  logic             neg_r, neg_nxt;
  logic [FIX_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r,  out_data_nxt;

  // shared adder
  logic [FIX_W-1:0] add_a, add_b, add_sum;
  logic             add_sub;

  // restoring divider step
  logic [DEN_W:0]   div_trial;
  logic             div_ge;
  logic [DEN_W-1:0] div_rem;
  logic [FIX_W-1:0] div_num;
  logic             div_last;

  // ms * rate times the reciprocal of 1000
  logic [PROD_W-1:0] tick_prod;

  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + {{(FIX_W-1){1'b0}}, add_sub};

  assign div_trial = {rem_r, num_r[FIX_W-1]};
  assign div_ge    = div_trial >= {1'b0, den_r};
  assign div_rem   = div_ge ? DEN_W'(div_trial - {1'b0, den_r}) : div_trial[DEN_W-1:0];
  assign div_num   = {num_r[FIX_W-2:0], div_ge};
  assign div_last  = cnt_r == CNT_W'(DIV_STEPS - 1);

  assign tick_prod = PROD_W'(num_r[MS_RATE_W-1:0]) * PROD_W'(RECIP_M);

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  always_comb begin
    state_nxt        = state_r;
    level_nxt        = level_r;
    target_nxt       = target_r;
    step_nxt         = step_r;
    ticks_nxt        = ticks_r;
    timer_active_nxt = timer_active_r;
    op_nxt           = op_r;
    ch_nxt           = ch_r;
    vol_nxt          = vol_r;
    ms_nxt           = ms_r;
    idx_nxt          = idx_r;
    push_nxt         = push_r;
    neg_nxt          = neg_r;
    num_nxt          = num_r;
    rem_nxt          = rem_r;
    den_nxt          = den_r;
    cnt_nxt          = cnt_r;
    out_valid_nxt    = out_valid_r;
    out_data_nxt     = out_data_r;
    add_a            = level_r[idx_r];
    add_b            = step_r[idx_r];
    add_sub          = 1'b0;

    if (cfg_valid) begin
      timer_active_nxt = cfg_data;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = op_t'(in_tuser[1:0]);
          ch_nxt    = in_tuser[2];
          vol_nxt   = in_tdata[VOL_W-1:0];
          ms_nxt    = in_tdata[VOL_W +: MS_W];
          push_nxt  = 2'b00;
          idx_nxt   = 1'b0;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        case (op_r)
          OP_TICK: begin
            state_nxt = S_TICK;
          end
          OP_SET: begin
            level_nxt[ch_r] = FIX_W'(vol_r) << FRAC_W;
            ticks_nxt[ch_r] = '0;
            push_nxt[ch_r]  = 1'b1;
            state_nxt       = S_DONE;
          end
          OP_START: begin
            if (timer_active_r) begin
              num_nxt   = FIX_W'({{(FIX_W-MS_W){1'b0}}, ms_r} * FIX_W'(TICK_RATE_HZ));
              state_nxt = S_DIV_MS;
            end else begin
              ticks_nxt[ch_r] = '0;
              state_nxt       = S_DONE;
            end
          end
          default: begin
            ticks_nxt[ch_r] = '0;
            state_nxt       = S_DONE;
          end
        endcase
      end

      // one fader per cycle through the shared adder
      S_TICK: begin
        if (ticks_r[idx_r] != '0) begin
          ticks_nxt[idx_r] = ticks_r[idx_r] - TICKS_W'(1);
          level_nxt[idx_r] = (ticks_r[idx_r] == TICKS_W'(1)) ? target_r[idx_r] : add_sum;
          push_nxt[idx_r]  = 1'b1;
        end
        if (idx_r) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = 1'b1;
        end
      end

      // ms * rate / 1000, plus one, from the reciprocal product
      S_DIV_MS: begin
        ticks_nxt[ch_r]  = tick_prod[RECIP_SH +: TICKS_W] + TICKS_W'(1);
        target_nxt[ch_r] = FIX_W'(vol_r) << FRAC_W;
        state_nxt        = S_DIFF;
      end

      S_DIFF: begin
        add_a     = target_r[ch_r];
        add_b     = level_r[ch_r];
        add_sub   = 1'b1;
        num_nxt   = add_sum;
        neg_nxt   = add_sum[FIX_W-1];
        state_nxt = S_ABS;
      end

      S_ABS: begin
        add_a   = '0;
        add_b   = num_r;
        add_sub = 1'b1;
        if (neg_r) begin
          num_nxt = add_sum;
        end
        den_nxt   = DEN_W'(ticks_r[ch_r]);
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV_STEP;
      end

      // |diff| / ticks, truncated
      S_DIV_STEP: begin
        num_nxt = div_num;
        rem_nxt = div_rem;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (div_last) begin
          state_nxt = S_NEG;
        end
      end

      // restore the sign: truncation toward zero
      S_NEG: begin
        add_a          = '0;
        add_b          = num_r;
        add_sub        = 1'b1;
        step_nxt[ch_r] = neg_r ? add_sum : num_r;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt = {{OUT_PAD_W{1'b0}},
                          push_r[1], push_r[0],
                          ticks_r[1] > TICKS_W'(1), ticks_r[0] > TICKS_W'(1),
                          level_r[1][FRAC_W +: VOL_W], level_r[0][FRAC_W +: VOL_W]};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      level_r[0]     <= FIX_W'(CD_RESET_VOL) << FRAC_W;
      level_r[1]     <= FIX_W'(MASTER_RESET_VOL) << FRAC_W;
      target_r[0]    <= '0;
      target_r[1]    <= '0;
      step_r[0]      <= '0;
      step_r[1]      <= '0;
      ticks_r[0]     <= '0;
      ticks_r[1]     <= '0;
      timer_active_r <= 1'b1;
      out_valid_r    <= 1'b0;
      idx_r          <= 1'b0;
      push_r         <= 2'b00;
      cnt_r          <= '0;
    end else begin
      state_r        <= state_nxt;
      level_r        <= level_nxt;
      target_r       <= target_nxt;
      step_r         <= step_nxt;
      ticks_r        <= ticks_nxt;
      timer_active_r <= timer_active_nxt;
      out_valid_r    <= out_valid_nxt;
      idx_r          <= idx_nxt;
      push_r         <= push_nxt;
      cnt_r          <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    ch_r       <= ch_nxt;
    vol_r      <= vol_nxt;
    ms_r       <= ms_nxt;
    neg_r      <= neg_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    out_data_r <= out_data_nxt;
  end

  // one request at a time
  `ASSERT_NEXT(a_one_req, clk, rst_n, in_tvalid && in_tready, !in_tready, "request overlap")
  // the step divide never sees a zero tick count
  `ASSERT_IMPL(a_den_nz, clk, rst_n, state_r == S_DIV_STEP, den_r != '0, "zero divisor")
  // tick counts stay within the longest fade
  `ASSERT_IMPL(a_ticks_max, clk, rst_n, 1'b1,
               ticks_r[0] <= TICKS_W'(MAX_TICKS) && ticks_r[1] <= TICKS_W'(MAX_TICKS),
               "tick count out of range")

endmodule
